// File: rtl/contiguous_cell_allocator_assert.svh
// Assertion macros for the allocator RTL.
`ifndef CONTIGUOUS_CELL_ALLOCATOR_ASSERT_SVH
`define CONTIGUOUS_CELL_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CCA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define CCA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/cca_pkg.sv
// Shared types, codes and widths for the contiguous cell allocator.
package cca_pkg;

  localparam int CELL_COUNT_DEF = 32;

  localparam int OP_W     = 1;
  localparam int LEN_W    = 6;
  localparam int START_W  = 5;
  localparam int STATUS_W = 2;
  localparam int FREE_W   = 6;
  localparam int CMP_W    = 8;

  localparam int IN_BITS     = OP_W + LEN_W + START_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = STATUS_W + START_W + FREE_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FEW    = 2'd1,
    ST_NOHOLE = 2'd2,
    ST_BAD    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_PICK,
    S_RUN,
    S_DONE
  } state_t;

  // Control from the sequencer to the hole tracker.
  typedef struct packed {
    logic clear;
    logic step;
    logic cell_free;
  } hole_ctl_t;

endpackage

// File: rtl/cca_hole.sv
// Best-fit hole tracker: follows free runs one cell per step and keeps the best.
module cca_hole #(
  parameter int CELL_COUNT = cca_pkg::CELL_COUNT_DEF,
  parameter int CW         = $clog2(CELL_COUNT + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cca_pkg::hole_ctl_t       ctl,
  input  logic [CW-1:0]            cell_idx,
  input  logic [cca_pkg::LEN_W-1:0] req_len,
  output logic                     found,
  output logic [CW-1:0]            best_start
);
  import cca_pkg::*;

  logic          found_r, found_nxt;
  logic [CW-1:0] hole_start_r, hole_start_nxt;
  logic [CW-1:0] hole_len_r, hole_len_nxt;
  logic [CW-1:0] best_start_r, best_start_nxt;
  logic [CW-1:0] best_len_r, best_len_nxt;
  logic          fits;

  // Hole closes here: does it hold the run and beat the best so far
  assign fits = (CMP_W'(hole_len_r) >= CMP_W'(req_len)) &&
                (!found_r || (hole_len_r < best_len_r));

  always_comb begin
    found_nxt      = found_r;
    hole_start_nxt = hole_start_r;
    hole_len_nxt   = hole_len_r;
    best_start_nxt = best_start_r;
    best_len_nxt   = best_len_r;
    if (ctl.clear) begin
      found_nxt    = 1'b0;
      hole_len_nxt = '0;
    end else if (ctl.step) begin
      if (ctl.cell_free) begin
        // extend the current hole, opening it if needed
        if (hole_len_r == '0) begin
          hole_start_nxt = cell_idx;
        end
        hole_len_nxt = hole_len_r + 1'b1;
      end else begin
        // close the hole and keep it if it is the tightest fit
        if (fits) begin
          found_nxt      = 1'b1;
          best_start_nxt = hole_start_r;
          best_len_nxt   = hole_len_r;
        end
        hole_len_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r    <= 1'b0;
      hole_len_r <= '0;
    end else begin
      found_r    <= found_nxt;
      hole_len_r <= hole_len_nxt;
    end
    hole_start_r <= hole_start_nxt;
    best_start_r <= best_start_nxt;
    best_len_r   <= best_len_nxt;
  end

  assign found      = found_r;
  assign best_start = best_start_r;

endmodule

// File: rtl/contiguous_cell_allocator.sv
// Bad requests and too-few-cells allocates go from the check straight to the result.
// One item at a time; the hole scan and run marking step one cell per cycle.
// Synchronous active-low reset frees every cell and empties the result register.
module contiguous_cell_allocator #(
  parameter int CELL_COUNT = cca_pkg::CELL_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [0] operation, [6:1] run_length, [11:7] run_start
  input  logic [cca_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [1:0] status, [6:2] granted_start, [12:7] free_cells
  output logic [cca_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import cca_pkg::*;
  `include "contiguous_cell_allocator_assert.svh"

  localparam int CW = $clog2(CELL_COUNT + 1);
  localparam int IW = $clog2(CELL_COUNT);

  state_t state_r, state_nxt;

  logic [CELL_COUNT-1:0] map_r;
  logic [CW-1:0]         free_cnt_r, free_cnt_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic [LEN_W-1:0]      rem_r, rem_nxt;
  op_t                   op_r;
  logic [LEN_W-1:0]      len_r;
  logic [START_W-1:0]    start_r;
  status_t               status_r, status_nxt;
  logic [START_W-1:0]    grant_r, grant_nxt;
  logic                  out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  logic      in_xfer;
  logic      bad_req, few_cells, cell_free, run_wr, out_load;
  hole_ctl_t hole_ctl;
  logic      hole_found;
  logic [CW-1:0] hole_best;

  assign in_xfer = in_tvalid && in_tready;

  // Request checks on the latched item
  assign bad_req = (len_r == '0) || (CMP_W'(len_r) > CMP_W'(CELL_COUNT)) ||
                   ((op_r == OP_RELEASE) &&
                    ((CMP_W'(start_r) + CMP_W'(len_r)) > CMP_W'(CELL_COUNT)));
  assign few_cells = CMP_W'(free_cnt_r) < CMP_W'(len_r);

  assign cell_free = (CMP_W'(idx_r) < CMP_W'(CELL_COUNT)) && !map_r[idx_r[IW-1:0]];

  cca_hole #(
    .CELL_COUNT (CELL_COUNT),
    .CW         (CW)
  ) u_hole (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (hole_ctl),
    .cell_idx   (idx_r),
    .req_len    (len_r),
    .found      (hole_found),
    .best_start (hole_best)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_xfer) state_nxt = S_CHECK;
      S_CHECK: begin
        if (bad_req || ((op_r == OP_ALLOC) && few_cells)) begin
          state_nxt = S_DONE;
        end else if (op_r == OP_ALLOC) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_RUN;
        end
      end
      S_SCAN:  if (CMP_W'(idx_r) == CMP_W'(CELL_COUNT)) state_nxt = S_PICK;
      S_PICK:  state_nxt = hole_found ? S_RUN : S_DONE;
      S_RUN:   if (rem_r == '0) state_nxt = S_DONE;
      S_DONE:  if (!out_tvalid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs and datapath control
  always_comb begin
    idx_nxt      = idx_r;
    rem_nxt      = rem_r;
    status_nxt   = status_r;
    grant_nxt    = grant_r;
    free_cnt_nxt = free_cnt_r;
    hole_ctl     = '0;
    run_wr       = 1'b0;
    out_load     = 1'b0;
    in_tready    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
      end
      S_CHECK: begin
        status_nxt     = ST_OK;
        grant_nxt      = '0;
        hole_ctl.clear = 1'b1;
        if (bad_req) begin
          status_nxt = ST_BAD;
        end else if ((op_r == OP_ALLOC) && few_cells) begin
          status_nxt = ST_FEW;
        end else if (op_r == OP_ALLOC) begin
          idx_nxt = '0;
        end else begin
          idx_nxt = CW'(start_r);
          rem_nxt = len_r;
        end
      end
      S_SCAN: begin
        // one cell per cycle, plus one step past the end to close the last hole
        hole_ctl.step      = 1'b1;
        hole_ctl.cell_free = cell_free;
        idx_nxt            = idx_r + 1'b1;
      end
      S_PICK: begin
        if (hole_found) begin
          idx_nxt   = hole_best;
          rem_nxt   = len_r;
          grant_nxt = START_W'(hole_best);
        end else begin
          status_nxt = ST_NOHOLE;
        end
      end
      S_RUN: begin
        if (rem_r != '0) begin
          run_wr  = 1'b1;
          idx_nxt = idx_r + 1'b1;
          rem_nxt = rem_r - 1'b1;
          if (op_r == OP_ALLOC) begin
            free_cnt_nxt = free_cnt_r - 1'b1;
          end else if (map_r[idx_r[IW-1:0]]) begin
            free_cnt_nxt = free_cnt_r + 1'b1;
          end
        end
      end
      S_DONE: begin
        out_load = !out_tvalid_r || out_tready;
      end
      default: begin
      end
    endcase
  end

  // Control registers and occupancy map
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      map_r        <= '0;
      free_cnt_r   <= CW'(CELL_COUNT);
      out_tvalid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      free_cnt_r <= free_cnt_nxt;
      if (run_wr) begin
        map_r[idx_r[IW-1:0]] <= (op_r == OP_ALLOC);
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r    <= op_t'(in_tdata[0]);
      len_r   <= in_tdata[OP_W +: LEN_W];
      start_r <= in_tdata[OP_W + LEN_W +: START_W];
    end
    idx_r    <= idx_nxt;
    rem_r    <= rem_nxt;
    status_r <= status_nxt;
    grant_r  <= grant_nxt;
    if (out_load) begin
      out_tdata_r <= OUT_TDATA_W'({FREE_W'(free_cnt_r), grant_r, status_r});
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `CCA_ASSERT_NOW(a_free_bound, clk, rst_n, 1'b1,
    CMP_W'(free_cnt_r) <= CMP_W'(CELL_COUNT), "free count above cell count")
  `CCA_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_xfer,
    !in_tready, "took a new item while one is in flight")
  `CCA_ASSERT_NOW(a_run_in_range, clk, rst_n, (state_r == S_RUN) && (rem_r != '0),
    CMP_W'(idx_r) < CMP_W'(CELL_COUNT), "run write past the last cell")
  `CCA_ASSERT_NOW(a_grant_zero_on_fail, clk, rst_n,
    out_tvalid && (out_tdata[1:0] != ST_OK),
    out_tdata[6:2] == '0, "nonzero start on a failed request")

endmodule
